### hw/rtl/trq_pkg.sv
// Shared types, codes and sizes of the timer and ready event queue.
package trq_pkg;

  localparam int EVENT_SLOTS = 32;
  localparam int TIME_BITS   = 64;
  localparam int SLOT_W      = $clog2(EVENT_SLOTS);
  localparam int PTR_W       = $clog2(EVENT_SLOTS + 1);
  localparam int CHILD_W     = SLOT_W + 1;

  // The null link of the FIFO is one past the last slot.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(EVENT_SLOTS);

  typedef enum logic [1:0] {
    MODE_ADD_TIMED = 2'd0,
    MODE_ADD_IMM   = 2'd1,
    MODE_CANCEL    = 2'd2,
    MODE_POLL      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_MISS      = 3'd3,
    KIND_READY     = 3'd4,
    KIND_NONE      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    Q_FREE = 2'd0,
    Q_HEAP = 2'd1,
    Q_FIFO = 2'd2
  } queued_t;

  typedef enum logic [1:0] {
    CONT_ADD,
    CONT_CANCEL,
    CONT_POLL
  } cont_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_ADD_LINK, ST_CAN_POS, ST_CAN_FIFO,
    ST_RM_START, ST_RM_LOAD, ST_DN_CHK, ST_DN_C1, ST_DN_C2, ST_DN_CMP,
    ST_UP_CHK, ST_UP_CMP, ST_PH_CHK, ST_PH_TEST, ST_PH_PEEK, ST_PH_PEEK2,
    ST_PF_CHK, ST_PF_NEXT, ST_EMIT_RD, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] deadline;
    logic [63:0] now_time;
    logic [7:0]  handler;
    logic [31:0] tag;
    logic [7:0]  event_flags;
    logic [4:0]  slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  out_slot;
    logic        wake;
    logic [7:0]  out_handler;
    logic [31:0] out_tag;
    logic [7:0]  out_flags;
    logic [63:0] next_deadline;
    logic        next_valid;
    logic        last;
  } rsp_t;

  // One heap entry carries its key next to the slot it orders.
  typedef struct packed {
    logic [TIME_BITS-1:0] key;
    logic [SLOT_W-1:0]    slot;
  } hent_t;

  typedef struct packed {
    logic [7:0]  handler;
    logic [31:0] tag;
    logic [7:0]  flags;
  } sdata_t;

endpackage

### hw/rtl/trq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module trq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/trq_ctrl.sv
// Sequencer of the event queue: slot pool, heap and FIFO walks over the RAMs.
module trq_ctrl
  import trq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  input  logic out_free,
  output logic emit,
  output rsp_t res_out
);

  state_t state, state_next;
  cont_t  cont, cont_next;
  req_t   cur_req, cur_req_next;
  logic [PTR_W-1:0] hcnt, hcnt_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  queued_t queued [EVENT_SLOTS];
  logic [SLOT_W-1:0] pos, pos_next;
  logic [SLOT_W-1:0] cidx, cidx_next;
  logic [SLOT_W-1:0] ev_slot, ev_slot_next;
  hent_t cur, cur_next;
  hent_t cand, cand_next;
  logic [TIME_BITS-1:0] rootk, rootk_next;
  logic last_r, last_r_next;
  rsp_t res, res_next;

  // RAM ports.
  logic heap_we, pos_we, dat_we, nxt_we, prv_we;
  logic [SLOT_W-1:0] heap_waddr, heap_raddr, pos_waddr, pos_raddr;
  logic [SLOT_W-1:0] dat_waddr, nxt_waddr, nxt_raddr, prv_waddr, prv_raddr;
  hent_t heap_wdata, heap_rdata;
  logic [SLOT_W-1:0] pos_wdata, pos_rdata;
  sdata_t dat_wdata, dat_rdata;
  logic [PTR_W-1:0] nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;

  // Slot state updates, one per cycle.
  logic q_we;
  logic [SLOT_W-1:0] q_idx;
  queued_t q_val;

  logic free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] cs;
  logic cancel_hit;
  logic [CHILD_W-1:0] child, child2;
  logic [SLOT_W-1:0] par;
  logic [TIME_BITS-1:0] now;
  logic heap_done;

  trq_ram #(.WIDTH($bits(hent_t)), .DEPTH(EVENT_SLOTS)) u_heap_ram (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  trq_ram #(.WIDTH(SLOT_W), .DEPTH(EVENT_SLOTS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  trq_ram #(.WIDTH($bits(sdata_t)), .DEPTH(EVENT_SLOTS)) u_dat_ram (
    .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
    .raddr(ev_slot), .rdata(dat_rdata)
  );

  trq_ram #(.WIDTH(PTR_W), .DEPTH(EVENT_SLOTS)) u_nxt_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata)
  );

  trq_ram #(.WIDTH(PTR_W), .DEPTH(EVENT_SLOTS)) u_prv_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(prv_raddr), .rdata(prv_rdata)
  );

  assign req_stall = (state != ST_IDLE);

  // Lowest-numbered free slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
      if (queued[i] == Q_FREE) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // Cancel target and heap index arithmetic.
  assign cs         = SLOT_W'(cur_req.slot);
  assign cancel_hit = (32'(cur_req.slot) < 32'(EVENT_SLOTS)) && (queued[cs] != Q_FREE);
  assign child      = {pos, 1'b1};
  assign child2     = CHILD_W'(cidx) + CHILD_W'(1);
  assign par        = (pos - SLOT_W'(1)) >> 1;
  assign now        = TIME_BITS'(cur_req.now_time);

  // Next state, RAM accesses and results.
  always_comb begin
    state_next   = state;
    cont_next    = cont;
    cur_req_next = cur_req;
    hcnt_next    = hcnt;
    head_next    = head;
    tail_next    = tail;
    pos_next     = pos;
    cidx_next    = cidx;
    ev_slot_next = ev_slot;
    cur_next     = cur;
    cand_next    = cand;
    rootk_next   = rootk;
    last_r_next  = last_r;
    res_next     = res;
    heap_we = 1'b0; heap_waddr = '0; heap_wdata = '0; heap_raddr = '0;
    pos_we  = 1'b0; pos_waddr  = '0; pos_wdata  = '0; pos_raddr  = '0;
    dat_we  = 1'b0; dat_waddr  = '0; dat_wdata  = '0;
    nxt_we  = 1'b0; nxt_waddr  = '0; nxt_wdata  = '0; nxt_raddr  = '0;
    prv_we  = 1'b0; prv_waddr  = '0; prv_wdata  = '0; prv_raddr  = '0;
    q_we = 1'b0; q_idx = '0; q_val = Q_FREE;
    emit = 1'b0;
    res_out = '0;
    heap_done = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cur_req_next = req;
          state_next   = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_next      = '0;
        res_next.last = 1'b1;
        unique case (cur_req.mode) inside
          MODE_ADD_TIMED, MODE_ADD_IMM: begin
            if (!free_found) begin
              res_next.kind = KIND_FULL;
              state_next    = ST_EMIT;
            end else begin
              dat_we       = 1'b1;
              dat_waddr    = free_slot;
              dat_wdata    = '{handler: cur_req.handler, tag: cur_req.tag,
                               flags: cur_req.event_flags};
              ev_slot_next = free_slot;
              q_we         = 1'b1;
              q_idx        = free_slot;
              if (cur_req.mode == MODE_ADD_TIMED) begin
                q_val      = Q_HEAP;
                cur_next   = '{key: TIME_BITS'(cur_req.deadline), slot: free_slot};
                pos_next   = SLOT_W'(hcnt);
                hcnt_next  = hcnt + PTR_W'(1);
                cont_next  = CONT_ADD;
                state_next = ST_UP_CHK;
              end else begin
                q_val     = Q_FIFO;
                nxt_we    = 1'b1;
                nxt_waddr = free_slot;
                nxt_wdata = NIL;
                prv_we    = 1'b1;
                prv_waddr = free_slot;
                prv_wdata = tail;
                res_next.kind     = KIND_ADDED;
                res_next.out_slot = 5'(free_slot);
                res_next.wake     = (head == NIL);
                if (tail == NIL) begin
                  head_next  = PTR_W'(free_slot);
                  tail_next  = PTR_W'(free_slot);
                  state_next = ST_EMIT;
                end else begin
                  state_next = ST_ADD_LINK;
                end
              end
            end
          end
          MODE_CANCEL: begin
            if (!cancel_hit) begin
              res_next.kind = KIND_MISS;
              state_next    = ST_EMIT;
            end else begin
              res_next.kind = KIND_CANCELLED;
              q_we          = 1'b1;
              q_idx         = cs;
              q_val         = Q_FREE;
              cont_next     = CONT_CANCEL;
              if (queued[cs] == Q_HEAP) begin
                pos_raddr  = cs;
                state_next = ST_CAN_POS;
              end else begin
                nxt_raddr  = cs;
                prv_raddr  = cs;
                state_next = ST_CAN_FIFO;
              end
            end
          end
          default: begin
            cont_next  = CONT_POLL;
            state_next = ST_PH_CHK;
          end
        endcase
      end

      ST_ADD_LINK: begin
        nxt_we     = 1'b1;
        nxt_waddr  = SLOT_W'(tail);
        nxt_wdata  = PTR_W'(ev_slot);
        tail_next  = PTR_W'(ev_slot);
        state_next = ST_EMIT;
      end

      ST_CAN_POS: begin
        pos_next   = pos_rdata;
        state_next = ST_RM_START;
      end

      // Unlink a FIFO entry from its neighbors.
      ST_CAN_FIFO: begin
        if (prv_rdata != NIL) begin
          nxt_we    = 1'b1;
          nxt_waddr = SLOT_W'(prv_rdata);
          nxt_wdata = nxt_rdata;
        end else begin
          head_next = nxt_rdata;
        end
        if (nxt_rdata != NIL) begin
          prv_we    = 1'b1;
          prv_waddr = SLOT_W'(nxt_rdata);
          prv_wdata = prv_rdata;
        end else begin
          tail_next = prv_rdata;
        end
        state_next = ST_EMIT;
      end

      // Heap removal: backfill from the last entry, then sift down and up.
      ST_RM_START: begin
        hcnt_next = hcnt - PTR_W'(1);
        if (PTR_W'(pos) == hcnt - PTR_W'(1)) begin
          heap_done = 1'b1;
        end else begin
          heap_raddr = SLOT_W'(hcnt - PTR_W'(1));
          state_next = ST_RM_LOAD;
        end
      end

      ST_RM_LOAD: begin
        cur_next   = heap_rdata;
        state_next = ST_DN_CHK;
      end

      ST_DN_CHK: begin
        if (CHILD_W'(pos) < CHILD_W'(hcnt >> 1)) begin
          heap_raddr = SLOT_W'(child);
          cidx_next  = SLOT_W'(child);
          state_next = ST_DN_C1;
        end else begin
          state_next = ST_UP_CHK;
        end
      end

      ST_DN_C1: begin
        cand_next = heap_rdata;
        if (child2 < CHILD_W'(hcnt)) begin
          heap_raddr = SLOT_W'(child2);
          state_next = ST_DN_C2;
        end else begin
          state_next = ST_DN_CMP;
        end
      end

      ST_DN_C2: begin
        if (heap_rdata.key < cand.key) begin
          cand_next = heap_rdata;
          cidx_next = SLOT_W'(child2);
        end
        state_next = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        if (cand.key < cur.key) begin
          heap_we    = 1'b1;
          heap_waddr = pos;
          heap_wdata = cand;
          pos_we     = 1'b1;
          pos_waddr  = cand.slot;
          pos_wdata  = pos;
          pos_next   = cidx;
          state_next = ST_DN_CHK;
        end else begin
          state_next = ST_UP_CHK;
        end
      end

      ST_UP_CHK: begin
        if (pos == '0) begin
          heap_we    = 1'b1;
          heap_waddr = pos;
          heap_wdata = cur;
          pos_we     = 1'b1;
          pos_waddr  = cur.slot;
          pos_wdata  = pos;
          heap_done  = 1'b1;
        end else begin
          heap_raddr = par;
          state_next = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        heap_we  = 1'b1;
        pos_we   = 1'b1;
        heap_waddr = pos;
        pos_wdata  = pos;
        if (cur.key < heap_rdata.key) begin
          heap_wdata = heap_rdata;
          pos_waddr  = heap_rdata.slot;
          pos_next   = par;
          state_next = ST_UP_CHK;
        end else begin
          heap_wdata = cur;
          pos_waddr  = cur.slot;
          heap_done  = 1'b1;
        end
      end

      // Poll: pop expired roots first.
      ST_PH_CHK: begin
        if (hcnt != '0) begin
          heap_raddr = '0;
          state_next = ST_PH_TEST;
        end else begin
          state_next = ST_PF_CHK;
        end
      end

      ST_PH_TEST: begin
        if (heap_rdata.key > now) begin
          rootk_next = heap_rdata.key;
          state_next = ST_PF_CHK;
        end else begin
          ev_slot_next = heap_rdata.slot;
          q_we         = 1'b1;
          q_idx        = heap_rdata.slot;
          q_val        = Q_FREE;
          pos_next     = '0;
          state_next   = ST_RM_START;
        end
      end

      // Look at the new root to learn whether this pop is the final result.
      ST_PH_PEEK: begin
        if (hcnt != '0) begin
          heap_raddr = '0;
          state_next = ST_PH_PEEK2;
        end else begin
          last_r_next = (head == NIL);
          state_next  = ST_EMIT_RD;
        end
      end

      ST_PH_PEEK2: begin
        last_r_next = (heap_rdata.key > now) && (head == NIL);
        state_next  = ST_EMIT_RD;
      end

      // Then drain the FIFO, or report the earliest deadline.
      ST_PF_CHK: begin
        if (head != NIL) begin
          ev_slot_next = SLOT_W'(head);
          nxt_raddr    = SLOT_W'(head);
          state_next   = ST_PF_NEXT;
        end else begin
          res_next.kind       = KIND_NONE;
          res_next.next_valid = (hcnt != '0);
          res_next.next_deadline = (hcnt != '0) ? 64'(rootk) : 64'd0;
          tail_next  = NIL;
          state_next = ST_EMIT;
        end
      end

      ST_PF_NEXT: begin
        head_next   = nxt_rdata;
        last_r_next = (nxt_rdata == NIL);
        q_we        = 1'b1;
        q_idx       = ev_slot;
        q_val       = Q_FREE;
        state_next  = ST_EMIT_RD;
      end

      ST_EMIT_RD: begin
        if (out_free) begin
          emit                = 1'b1;
          res_out.kind        = KIND_READY;
          res_out.out_slot    = 5'(ev_slot);
          res_out.out_handler = dat_rdata.handler;
          res_out.out_tag     = dat_rdata.tag;
          res_out.out_flags   = dat_rdata.flags;
          res_out.last        = last_r;
          if (last_r) begin
            head_next  = NIL;
            tail_next  = NIL;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_PH_CHK;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          res_out    = res;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // A finished heap update resumes the operation that started it.
    if (heap_done) begin
      unique case (cont)
        CONT_ADD: begin
          res_next          = '0;
          res_next.kind     = KIND_ADDED;
          res_next.out_slot = 5'(cur.slot);
          res_next.wake     = (pos == '0);
          res_next.last     = 1'b1;
          state_next        = ST_EMIT;
        end
        CONT_CANCEL: state_next = ST_EMIT;
        default:     state_next = ST_PH_PEEK;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hcnt  <= '0;
      head  <= NIL;
      tail  <= NIL;
    end else begin
      state <= state_next;
      hcnt  <= hcnt_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  // Per-slot queue membership.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        queued[i] <= Q_FREE;
      end
    end else if (q_we) begin
      queued[q_idx] <= q_val;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cont    <= cont_next;
    cur_req <= cur_req_next;
    pos     <= pos_next;
    cidx    <= cidx_next;
    ev_slot <= ev_slot_next;
    cur     <= cur_next;
    cand    <= cand_next;
    rootk   <= rootk_next;
    last_r  <= last_r_next;
    res     <= res_next;
  end

  a_hcnt_range: assert property (@(posedge clk) disable iff (rst)
    hcnt <= PTR_W'(EVENT_SLOTS))
    else $error("heap count beyond pool size");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result issued into a busy output register");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_DISPATCH))
    else $error("accepted request not dispatched");

  a_fifo_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((head == NIL) == (tail == NIL)))
    else $error("FIFO head and tail disagree on emptiness");

endmodule

### hw/rtl/timer_and_ready_event_queue.sv
// Top level of the timer and ready event queue: sequencer and output register.
//
// Each request is taken alone; the block stalls its request side until every
// result of the previous request has been handed to the output register. An
// immediate add or a miss needs no heap work; a timed add climbs the heap level
// by level; a cancel of a timer and each timer released by a poll cost a
// backfill from the last heap entry, a sift-down and a sift-up, and a poll then
// checks the new root; each FIFO event released is read and unlinked at the head.
// Heap work is set by the heap RAM, whose single read port serves one parent or
// child per cycle, and with 32 slots a heap operation spans at most five levels.
// The output register lets the next request be taken while the last result
// still waits on a stalled consumer.
module timer_and_ready_event_queue
  import trq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic out_free;
  logic emit;
  rsp_t res_out;

  assign out_free = !rsp_valid || !rsp_stall;

  trq_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .out_free(out_free),
    .emit(emit),
    .res_out(res_out)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= res_out;
    end
  end

endmodule
